### rtl/core/sfla_pkg.sv
// sfla_pkg: shared types and fixed constants for the slab free-list allocator
// no dependencies; imported by slab_free_list_allocator
`timescale 1ns / 1ps
`default_nettype none

package sfla_pkg;

  localparam int CNT_W       = 11;
  localparam int IDX_OUT_W   = 10;
  localparam int SC_W        = 11;

  localparam logic [CNT_W-1:0] COUNT_MAX      = 11'd2047;
  localparam logic [SC_W-1:0]  SLOT_COUNT_RST = 11'd1024;
  localparam logic [SC_W-1:0]  SLOT_COUNT_MIN = 11'd2;

  typedef enum logic [1:0] {
    REQ_ALLOC  = 2'd0,
    REQ_FREE   = 2'd1,
    REQ_FORMAT = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ALLOC_RD,
    S_FORMAT
  } state_t;

endpackage

`default_nettype wire

### rtl/core/slab_free_list_allocator.sv
// slab_free_list_allocator: free-list slot allocator built around one link memory; uses sfla_pkg
// flow: free, bad requests and refused allocates load the result on accept; allocate first reads
// the link memory; format accepts, then writes one link per cycle for the clamped slot_count
// throughput: one transaction in flight, next accepted in the cycle its result leaves
// reset (rst_n, synchronous): both lists empty, count zero, slot_count 1024; the link memory is
// not cleared and holds nothing valid until the first format
`timescale 1ns / 1ps
`default_nettype none

module slab_free_list_allocator #(
  parameter int MAX_SLOTS = 1024
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // configuration: slot_count
  input  wire logic                            cfg_wr_en,
  input  wire logic [sfla_pkg::SC_W-1:0]       cfg_wr_data,
  // request channel
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [1:0]                      in_req_type,
  input  wire logic [9:0]                      in_slot_index,
  input  wire logic                            in_is_local,
  input  wire logic                            in_is_list_head,
  // result channel
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 out_ok,
  output logic [sfla_pkg::IDX_OUT_W-1:0]       out_granted_index,
  output logic                                 out_became_empty,
  output logic                                 out_half_empty
);

  import sfla_pkg::*;

  // link entries carry a slot index plus an end flag in the top bit
  localparam int AW     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int LINK_W = AW + 1;
  localparam logic [LINK_W-1:0] END_LINK = {LINK_W{1'b1}};

  // link memory, one entry per slot, synchronous read
  logic [LINK_W-1:0] link_mem [MAX_SLOTS];
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [LINK_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [LINK_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= link_mem[mem_raddr];
  end

  // control and list state
  state_t            state_r, state_nxt;
  logic [SC_W-1:0]   slot_count_r;
  logic [LINK_W-1:0] local_head_r, local_head_nxt;
  logic [LINK_W-1:0] global_head_r, global_head_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [AW-1:0]     fmt_idx_r, fmt_idx_nxt;

  // result register
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_ok_r;
  logic [IDX_OUT_W-1:0]  out_idx_r;
  logic                  out_empty_r;
  logic                  out_half_r;
  logic                  res_load;
  logic                  res_ok;
  logic [IDX_OUT_W-1:0]  res_idx;
  logic                  res_empty;
  logic                  res_half;

  logic              accept;
  logic [SC_W-1:0]   sc_eff;
  logic [LINK_W-1:0] take_head;
  logic              free_in_range;
  logic [CNT_W-1:0]  count_dec;
  logic              fmt_last;
  logic              link_ok;

  // slot_count clamped to [2, MAX_SLOTS]
  always_comb begin
    if (slot_count_r < SLOT_COUNT_MIN) begin
      sc_eff = SLOT_COUNT_MIN;
    end else if (32'(slot_count_r) > 32'(MAX_SLOTS)) begin
      sc_eff = SC_W'(MAX_SLOTS);
    end else begin
      sc_eff = slot_count_r;
    end
  end

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  // allocate takes over the global list when the local one is empty
  assign take_head     = local_head_r[LINK_W-1] ? global_head_r : local_head_r;
  assign free_in_range = ({1'b0, in_slot_index} < sc_eff);
  assign count_dec     = (count_r != '0) ? (count_r - 1'b1) : count_r;
  assign fmt_last      = ((32'(fmt_idx_r) + 32'd1) == 32'(sc_eff));
  // a link outside the pool ends the list
  assign link_ok       = (32'(rd_data_r) < 32'(MAX_SLOTS));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (req_t'(in_req_type))
            REQ_ALLOC: begin
              if (!take_head[LINK_W-1]) begin
                state_nxt = S_ALLOC_RD;
              end
            end
            REQ_FORMAT: state_nxt = S_FORMAT;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_ALLOC_RD: state_nxt = S_IDLE;
      S_FORMAT: begin
        if (fmt_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath, memory access and result
  always_comb begin
    local_head_nxt  = local_head_r;
    global_head_nxt = global_head_r;
    count_nxt       = count_r;
    fmt_idx_nxt     = fmt_idx_r;
    mem_we          = 1'b0;
    mem_waddr       = '0;
    mem_wdata       = '0;
    mem_raddr       = '0;
    res_load        = 1'b0;
    res_ok          = 1'b0;
    res_idx         = '0;
    res_empty       = 1'b0;
    res_half        = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (req_t'(in_req_type))
            REQ_ALLOC: begin
              if (!take_head[LINK_W-1]) begin
                // issue the link read, pop completes next cycle
                local_head_nxt = take_head;
                if (local_head_r[LINK_W-1]) begin
                  global_head_nxt = END_LINK;
                end
                mem_raddr = take_head[AW-1:0];
              end else begin
                res_load = 1'b1;
              end
            end
            REQ_FREE: begin
              res_load = 1'b1;
              if (free_in_range) begin
                mem_we    = 1'b1;
                mem_waddr = AW'(in_slot_index);
                if (in_is_local) begin
                  mem_wdata      = local_head_r;
                  local_head_nxt = LINK_W'(in_slot_index);
                end else begin
                  mem_wdata       = global_head_r;
                  global_head_nxt = LINK_W'(in_slot_index);
                end
                count_nxt = count_dec;
                res_ok    = 1'b1;
                if (count_r != '0 && !in_is_list_head) begin
                  res_empty = (count_dec == '0);
                  res_half  = (count_dec == (sc_eff >> 1));
                end
              end
            end
            REQ_FORMAT: begin
              fmt_idx_nxt = '0;
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      S_ALLOC_RD: begin
        res_load       = 1'b1;
        res_ok         = 1'b1;
        res_idx        = IDX_OUT_W'(local_head_r[AW-1:0]);
        local_head_nxt = link_ok ? rd_data_r : END_LINK;
        if (count_r != COUNT_MAX) begin
          count_nxt = count_r + 1'b1;
        end
      end
      S_FORMAT: begin
        // chain slot i to slot i+1, last slot ends the list
        mem_we    = 1'b1;
        mem_waddr = fmt_idx_r;
        if (fmt_last) begin
          mem_wdata       = END_LINK;
          local_head_nxt  = '0;
          global_head_nxt = END_LINK;
          count_nxt       = '0;
          res_load        = 1'b1;
          res_ok          = 1'b1;
        end else begin
          mem_wdata   = LINK_W'(fmt_idx_r) + 1'b1;
          fmt_idx_nxt = fmt_idx_r + 1'b1;
        end
      end
      default: begin
        res_load = 1'b0;
      end
    endcase

    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      slot_count_r  <= SLOT_COUNT_RST;
      local_head_r  <= END_LINK;
      global_head_r <= END_LINK;
      count_r       <= '0;
      fmt_idx_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      local_head_r  <= local_head_nxt;
      global_head_r <= global_head_nxt;
      count_r       <= count_nxt;
      fmt_idx_r     <= fmt_idx_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_wr_en) begin
        slot_count_r <= cfg_wr_data;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (res_load) begin
      out_ok_r    <= res_ok;
      out_idx_r   <= res_idx;
      out_empty_r <= res_empty;
      out_half_r  <= res_half;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_ok            = out_ok_r;
  assign out_granted_index = out_idx_r;
  assign out_became_empty  = out_empty_r;
  assign out_half_empty    = out_half_r;

  // a pop always completes in the cycle after its link read
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ALLOC_RD |=> state_r == S_IDLE && out_valid_r && out_ok_r)
    else $error("allocate did not complete after link read");

  // allocate with both lists empty fails right away
  assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_req_type == REQ_ALLOC && local_head_r[LINK_W-1] && global_head_r[LINK_W-1]
    |=> out_valid_r && !out_ok_r && state_r == S_IDLE)
    else $error("allocate on empty lists did not fail");

  // format leaves the global list empty and the local list at slot zero
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FORMAT && fmt_last
    |=> global_head_r == END_LINK && local_head_r == '0 && count_r == '0)
    else $error("format end state wrong");

  // a pop never hands out an ended list head
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ALLOC_RD |-> !local_head_r[LINK_W-1])
    else $error("pop from empty local list");

endmodule

`default_nettype wire

### sim/tb_top.sv
// tb_top: self-checking bench for slab_free_list_allocator, with a predictor of both free lists
// runs directed and randomized request phases over a sweep of slot_count values
// depends on sfla_pkg and slab_free_list_allocator
`timescale 1ns / 1ps

module tb_top;
  import sfla_pkg::*;

  localparam int          POOL_SLOTS     = 1024;
  localparam logic [10:0] LINK_END       = 11'h7ff;  // end marker as held in an 11-bit link
  localparam logic [1:0]  REQ_UNKNOWN    = 2'd3;     // request code the block must reject
  localparam int          WATCHDOG_LIMIT = 4000;     // a full format plus the longest stall
  localparam int          PHASE_ITEMS    = 95;

  // one request transaction and one result transaction
  typedef struct packed {
    logic [1:0] req;
    logic [9:0] slot;
    logic       is_local;
    logic       is_head;
  } slab_req_t;

  typedef struct packed {
    logic       ok;
    logic [9:0] granted;
    logic       became_empty;
    logic       half_empty;
  } slab_resp_t;

  logic                 clk;
  logic                 rst_n             = 1'b0;
  logic                 cfg_wr_en         = 1'b0;
  logic [SC_W-1:0]      cfg_wr_data       = '0;
  logic                 in_valid          = 1'b0;
  logic                 in_ready;
  logic [1:0]           in_req_type       = '0;
  logic [9:0]           in_slot_index     = '0;
  logic                 in_is_local       = 1'b0;
  logic                 in_is_list_head   = 1'b0;
  logic                 out_valid;
  logic                 out_ready         = 1'b0;
  logic                 out_ok;
  logic [IDX_OUT_W-1:0] out_granted_index;
  logic                 out_became_empty;
  logic                 out_half_empty;

  slab_free_list_allocator #(.MAX_SLOTS(POOL_SLOTS)) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_slot_index     (in_slot_index),
    .in_is_local       (in_is_local),
    .in_is_list_head   (in_is_list_head),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_ok            (out_ok),
    .out_granted_index (out_granted_index),
    .out_became_empty  (out_became_empty),
    .out_half_empty    (out_half_empty)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // shadow of the allocator: link memory, both list heads, allocation count and
  // the live slot_count register; written only by the sampling block below
  // ---------------------------------------------------------------------------
  logic [10:0] link_mem [POOL_SLOTS];
  logic [10:0] local_head_q  = LINK_END;
  logic [10:0] global_head_q = LINK_END;
  logic [10:0] count_q       = '0;
  logic [10:0] slot_count_q  = SLOT_COUNT_RST;

  slab_req_t   pending_reqs [$];    // filled by the sequence, drained by the driver
  slab_resp_t  expected_resps [$];  // one entry per accepted request
  logic [9:0]  held_slots [$];      // slots granted and not yet given back

  int issued_cnt   = 0;
  int accepted_cnt = 0;
  int err_count    = 0;
  int n_grants     = 0;
  int n_alloc_fail = 0;
  int n_frees      = 0;
  int n_formats    = 0;
  int n_empty_flag = 0;
  int n_half_flag  = 0;
  int n_settings   = 1;
  int idle_cycles  = 0;

  // slot_count is used live and clamped to the supported range
  function automatic logic [10:0] active_slots();
    if (slot_count_q < SLOT_COUNT_MIN) return SLOT_COUNT_MIN;
    if (slot_count_q > POOL_SLOTS) return 11'(POOL_SLOTS);
    return slot_count_q;
  endfunction

  // advances the shadow by one request and returns the result it must produce
  task automatic apply_slab_request(input slab_req_t r, output slab_resp_t res);
    logic [10:0] sc;
    logic [10:0] slot;
    int          hit [$];
    int          i;
    sc  = active_slots();
    res = '0;
    case (r.req)
      REQ_ALLOC: begin
        // local list dry: adopt the whole global list first
        if (local_head_q >= POOL_SLOTS && global_head_q < POOL_SLOTS) begin
          local_head_q  = global_head_q;
          global_head_q = LINK_END;
        end
        if (local_head_q < POOL_SLOTS) begin
          slot         = local_head_q;
          // a link that points past the pool ends the list
          local_head_q = (link_mem[slot] < POOL_SLOTS) ? link_mem[slot] : LINK_END;
          if (count_q != COUNT_MAX) count_q = count_q + 11'd1;
          res.ok      = 1'b1;
          res.granted = slot[9:0];
          held_slots.push_back(slot[9:0]);
          n_grants++;
        end else begin
          n_alloc_fail++;
        end
      end
      REQ_FREE: begin
        if ({1'b0, r.slot} < sc) begin
          if (r.is_local) begin
            link_mem[r.slot] = local_head_q;
            local_head_q     = {1'b0, r.slot};
          end else begin
            link_mem[r.slot] = global_head_q;
            global_head_q    = {1'b0, r.slot};
          end
          // count saturates at zero, and then no flag is raised
          if (count_q != 0) begin
            count_q = count_q - 11'd1;
            if (!r.is_head) begin
              res.became_empty = (count_q == 0);
              res.half_empty   = (count_q == (sc >> 1));
            end
          end
          res.ok = 1'b1;
          hit = held_slots.find_first_index(x) with (x == r.slot);
          if (hit.size() > 0) held_slots.delete(hit[0]);
          n_frees++;
          if (res.became_empty) n_empty_flag++;
          if (res.half_empty) n_half_flag++;
        end
      end
      REQ_FORMAT: begin
        // chain slots 0..sc-1 in order onto the local list
        for (i = 0; i < sc; i++)
          link_mem[i] = (i + 1 < sc) ? 11'(i + 1) : LINK_END;
        local_head_q  = '0;
        global_head_q = LINK_END;
        count_q       = '0;
        res.ok        = 1'b1;
        held_slots.delete();
        n_formats++;
      end
      default: begin
        // unknown code: rejected, state untouched
      end
    endcase
  endtask

  task automatic report_field(input string field, input int want, input int got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // driver: bursts of requests with random gaps, payload held until accepted
  // ---------------------------------------------------------------------------
  slab_req_t next_req;
  int        burst_left = 1;
  int        gap_left   = 0;

  always @(negedge clk) begin
    if (in_valid && accepted_cnt != issued_cnt) begin
      // transaction still waiting for in_ready
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left--;
    end else if (pending_reqs.size() > 0) begin
      next_req = pending_reqs.pop_front();
      issued_cnt++;
      in_valid        <= 1'b1;
      in_req_type     <= next_req.req;
      in_slot_index   <= next_req.slot;
      in_is_local     <= next_req.is_local;
      in_is_list_head <= next_req.is_head;
      if (burst_left <= 1) begin
        burst_left = $urandom_range(1, 16);
        // about a quarter of the bursts run straight into the next one
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left--;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: out_ready follows a rotating pattern that is replaced now and then
  // ---------------------------------------------------------------------------
  logic [31:0] stall_pattern = '1;
  int          stall_age     = 0;

  always @(negedge clk) begin
    if (stall_age == 0) begin
      case ($urandom_range(0, 3))
        0:       stall_pattern = '1;                        // no back-pressure
        1:       stall_pattern = $urandom() | 32'h1;        // random stalls
        2:       stall_pattern = 32'h0000_0101;             // long stalls
        default: stall_pattern = $urandom() | $urandom();   // light stalls
      endcase
      stall_age = $urandom_range(16, 96);
    end
    out_ready     <= stall_pattern[0];
    stall_pattern  = {stall_pattern[0], stall_pattern[31:1]};
    stall_age--;
  end

  // ---------------------------------------------------------------------------
  // sampling at the rising edge: result check, prediction, watchdog
  // ---------------------------------------------------------------------------
  slab_resp_t seen_resp;
  slab_resp_t want_resp;
  slab_resp_t new_resp;
  slab_req_t  taken_req;

  always @(posedge clk) begin
    if (rst_n) begin
      // register writes only happen while the block is idle
      if (cfg_wr_en) slot_count_q = cfg_wr_data;

      // result side first, so a request accepted on this edge queues behind
      if (out_valid && out_ready) begin
        seen_resp.ok           = out_ok;
        seen_resp.granted      = out_granted_index;
        seen_resp.became_empty = out_became_empty;
        seen_resp.half_empty   = out_half_empty;
        if (expected_resps.size() == 0) begin
          $display("%0t: result with nothing outstanding, expected none, got ok=%0b index=%0d",
                   $time, seen_resp.ok, seen_resp.granted);
          err_count++;
        end else begin
          want_resp = expected_resps.pop_front();
          if (seen_resp.ok != want_resp.ok)
            report_field("ok", want_resp.ok, seen_resp.ok);
          if (seen_resp.granted != want_resp.granted)
            report_field("granted_index", want_resp.granted, seen_resp.granted);
          if (seen_resp.became_empty != want_resp.became_empty)
            report_field("became_empty", want_resp.became_empty, seen_resp.became_empty);
          if (seen_resp.half_empty != want_resp.half_empty)
            report_field("half_empty", want_resp.half_empty, seen_resp.half_empty);
        end
      end

      if (in_valid && in_ready) begin
        taken_req.req      = in_req_type;
        taken_req.slot     = in_slot_index;
        taken_req.is_local = in_is_local;
        taken_req.is_head  = in_is_list_head;
        apply_slab_request(taken_req, new_resp);
        expected_resps.push_back(new_resp);
        accepted_cnt++;
      end

      // watchdog: any transaction or register write counts as progress
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("slab_free_list_allocator test failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  task automatic push_req(input logic [1:0] req, input logic [9:0] slot,
                          input logic is_local, input logic is_head);
    slab_req_t r;
    r.req      = req;
    r.slot     = slot;
    r.is_local = is_local;
    r.is_head  = is_head;
    pending_reqs.push_back(r);
  endtask

  // block is idle once every queued request has been answered
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || accepted_cnt != issued_cnt ||
           expected_resps.size() != 0);
  endtask

  task automatic write_slot_count(input logic [10:0] value);
    wait_idle();
    repeat (4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    n_settings++;
  endtask

  // mostly well-formed traffic: allocs and frees of slots actually held, plus
  // a share of stray frees, out-of-pool frees, bad codes and re-formats
  task automatic queue_random_batch(input int n);
    logic [9:0]  spare [$];
    logic [10:0] sc;
    slab_req_t   r;
    int          roll;
    int          pick;
    spare = held_slots;
    sc    = active_slots();
    repeat (n) begin
      r.req      = REQ_ALLOC;
      r.slot     = 10'($urandom());
      r.is_local = 1'($urandom());
      r.is_head  = 1'($urandom());
      roll       = $urandom_range(0, 99);
      if (roll < 42 || (roll < 82 && spare.size() == 0)) begin
        r.req = REQ_ALLOC;
      end else if (roll < 82) begin
        pick      = $urandom_range(0, spare.size() - 1);
        r.req     = REQ_FREE;
        r.slot    = spare[pick];
        r.is_head = ($urandom_range(0, 3) == 0);
        spare.delete(pick);
      end else if (roll < 88) begin
        r.req = REQ_FREE;  // stray slot, may be a double free
      end else if (roll < 93) begin
        r.req = REQ_FREE;
        if (sc < POOL_SLOTS) r.slot = 10'($urandom_range(sc, POOL_SLOTS - 1));
      end else if (roll < 97) begin
        r.req = REQ_UNKNOWN;
      end else begin
        r.req = REQ_FORMAT;
      end
      pending_reqs.push_back(r);
    end
  endtask

  initial begin
    logic [10:0] sweep [10];
    int          k;
    int          queued;
    int          batch;
    sweep = '{11'd4, 11'd7, 11'd16, 11'd1, 11'd3, 11'd33, 11'd2047, 11'd1024, 11'd9, 11'd5};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset slot_count: bad code, free with zero count into the
    // global list, alloc adopting the global list, empty flag, full format
    push_req(REQ_UNKNOWN, 10'd1023, 1'b1, 1'b1);
    push_req(REQ_FREE,    10'd1023, 1'b0, 1'b0);
    push_req(REQ_ALLOC,   10'd0,    1'b0, 1'b0);
    push_req(REQ_FREE,    10'd0,    1'b1, 1'b0);
    push_req(REQ_FORMAT,  10'd0,    1'b0, 1'b0);
    push_req(REQ_ALLOC,   10'd1023, 1'b1, 1'b1);
    push_req(REQ_ALLOC,   10'd0,    1'b0, 1'b0);
    push_req(REQ_FREE,    10'd1,    1'b1, 1'b1);

    // directed, smallest pool: exhaust, free past the pool, half flag,
    // list head suppressing the empty flag, then adopt the global list
    write_slot_count(11'd2);
    push_req(REQ_FORMAT,  10'd0,    1'b0, 1'b0);
    push_req(REQ_ALLOC,   10'd0,    1'b0, 1'b0);
    push_req(REQ_ALLOC,   10'd0,    1'b0, 1'b0);
    push_req(REQ_ALLOC,   10'd0,    1'b0, 1'b0);
    push_req(REQ_FREE,    10'd2,    1'b1, 1'b0);
    push_req(REQ_FREE,    10'd1,    1'b0, 1'b0);
    push_req(REQ_FREE,    10'd0,    1'b1, 1'b1);
    push_req(REQ_ALLOC,   10'd0,    1'b0, 1'b0);
    push_req(REQ_ALLOC,   10'd0,    1'b0, 1'b0);

    // directed, slot_count below the minimum acts as two
    write_slot_count(11'd0);
    push_req(REQ_FORMAT,  10'd0,    1'b0, 1'b0);
    push_req(REQ_ALLOC,   10'd0,    1'b0, 1'b0);
    push_req(REQ_ALLOC,   10'd0,    1'b0, 1'b0);
    push_req(REQ_ALLOC,   10'd0,    1'b0, 1'b0);
    push_req(REQ_FREE,    10'd1,    1'b1, 1'b0);
    push_req(REQ_FREE,    10'd0,    1'b0, 1'b0);

    // random phases over a sweep of pool sizes, each starting from a format
    for (k = 0; k < 10; k++) begin
      write_slot_count(sweep[k]);
      push_req(REQ_FORMAT, 10'($urandom()), 1'($urandom()), 1'($urandom()));
      wait_idle();
      queued = 1;
      while (queued < PHASE_ITEMS) begin
        batch = $urandom_range(6, 40);
        if (batch > PHASE_ITEMS - queued) batch = PHASE_ITEMS - queued;
        queue_random_batch(batch);
        queued += batch;
        wait_idle();
      end
    end

    // drain, then wait for anything unexpected to show up
    wait_idle();
    repeat (8) @(posedge clk);

    $display("covered %0d requests: %0d grants, %0d refused allocs, %0d frees, %0d formats",
             accepted_cnt, n_grants, n_alloc_fail, n_frees, n_formats);
    $display("raised %0d became-empty and %0d half-empty flags across %0d slot_count values",
             n_empty_flag, n_half_flag, n_settings);
    if (err_count == 0 && expected_resps.size() == 0) begin
      $display("slab_free_list_allocator test passed");
    end else begin
      $display("slab_free_list_allocator test failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/sfla_pkg.sv
rtl/core/slab_free_list_allocator.sv
sim/tb_top.sv
